// ===== hdl/nsrank_pkg.sv =====
// Shared types and constants of the null-stratified rank accuracy block.
`timescale 1ns / 1ps

package nsrank_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int DATA_W        = 16;
    localparam int EPS_W         = 15;
    localparam int TIE_W         = 9;
    localparam int CFG_W         = 15;
    localparam int ACC_W         = 17;
    localparam int PTOT_W        = 19;

    localparam logic [TIE_W-1:0]  SCORE_ONE      = 9'd256;
    localparam logic [TIE_W-1:0]  TIE_RESET      = 9'd128;
    localparam logic [EPS_W-1:0]  EPS_RESET      = '0;
    localparam logic [ACC_W-1:0]  ACC_ONE        = 17'h10000;
    localparam logic [PTOT_W-1:0] PAIR_FIELD_MAX = '1;

    typedef enum logic [0:0] {
        REG_EPSILON    = 1'b0,
        REG_TIE_CREDIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic store;
        logic active;
        logic up;
        logic last;
        logic ovf;
    } tok_ctl_t;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_OUT  = 3'b100
    } div_state_t;

endpackage

// ===== hdl/null_stratified_rank_accuracy.sv =====
// Top level: config registers, entry stage, row of scoring cells, tail accumulator.
// Throughput: one beat per cycle; the row of cells stalls only while a last beat
//   waits at the tail for the divider to finish the previous set (its 17 division
//   steps and the result beat, plus any wait for m_ready).
// A last beat reaches m_valid through the entry register, the cell row and the
//   17-step divider, whose steps are skipped when no pair exists.
// Reset: synchronous active-low aresetn clears control state and sets epsilon 0,
//   tie credit 128; item stores need no clearing, so no sweep follows reset.
`timescale 1ns / 1ps

module null_stratified_rank_accuracy #(
    parameter int MAX_ITEMS = nsrank_pkg::MAX_ITEMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_idx,
    input  logic [nsrank_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [nsrank_pkg::DATA_W-1:0] s_measured,
    input  logic signed [nsrank_pkg::DATA_W-1:0] s_predicted,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nsrank_pkg::ACC_W-1:0]        m_accuracy,
    output logic [nsrank_pkg::PTOT_W-1:0]       m_pair_total,
    output logic                                m_undefined,
    output logic                                m_overflowed
);

    localparam int IDX_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int TSCORE_W = IDX_W + 8;
    localparam int PAIR_W   = 2 * IDX_W;
    localparam int SUM_W    = PAIR_W + 8;
    localparam int DATA_W   = nsrank_pkg::DATA_W;

    logic [nsrank_pkg::EPS_W-1:0]  eps_reg;
    logic [nsrank_pkg::TIE_W-1:0]  tie_reg;

    logic [CNT_W-1:0]              item_count_reg;
    logic                          ovf_reg;

    nsrank_pkg::tok_ctl_t          ctl_chain   [MAX_ITEMS+1];
    logic [IDX_W-1:0]              idx_chain   [MAX_ITEMS+1];
    logic [DATA_W-1:0]             pred_chain  [MAX_ITEMS+1];
    logic [TSCORE_W-1:0]           score_chain [MAX_ITEMS+1];
    logic [IDX_W-1:0]              pairs_chain [MAX_ITEMS+1];

    nsrank_pkg::tok_ctl_t          ent_ctl_reg;
    logic [IDX_W-1:0]              ent_idx_reg;
    logic [DATA_W-1:0]             ent_pred_reg;

    logic [SUM_W-1:0]              sum_reg;
    logic [PAIR_W-1:0]             pairs_reg;

    logic                          adv;
    logic                          accept;
    logic                          full;
    logic signed [DATA_W:0]        m_ext;
    logic signed [DATA_W:0]        eps_ext;
    logic                          is_up;
    logic                          is_down;
    logic                          div_idle;
    logic                          div_start;
    logic [SUM_W-1:0]              total_sum;
    logic [PAIR_W-1:0]             total_pairs;
    nsrank_pkg::tok_ctl_t          tail_ctl;

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= nsrank_pkg::EPS_RESET;
            tie_reg <= nsrank_pkg::TIE_RESET;
        end else if (cfg_we) begin
            case (nsrank_pkg::cfg_reg_t'(cfg_idx))
                nsrank_pkg::REG_EPSILON: begin
                    eps_reg <= cfg_data;
                end
                nsrank_pkg::REG_TIE_CREDIT: begin
                    tie_reg <= (cfg_data[nsrank_pkg::TIE_W-1:0] > nsrank_pkg::SCORE_ONE) ?
                               nsrank_pkg::SCORE_ONE : cfg_data[nsrank_pkg::TIE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // entry stage: dead-band classification and item numbering
    assign tail_ctl  = ctl_chain[MAX_ITEMS];
    assign adv       = !(tail_ctl.valid && tail_ctl.last && !div_idle);
    assign s_ready   = adv;
    assign accept    = s_valid && s_ready;
    assign full      = item_count_reg == CNT_W'(MAX_ITEMS);
    assign m_ext     = {s_measured[DATA_W-1], s_measured};
    assign eps_ext   = {2'b00, eps_reg};
    assign is_up     = m_ext > eps_ext;
    assign is_down   = m_ext < -eps_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= '0;
            ovf_reg        <= 1'b0;
            ent_ctl_reg    <= '0;
        end else if (adv) begin
            ent_ctl_reg.valid  <= accept;
            ent_ctl_reg.store  <= !full;
            ent_ctl_reg.active <= !full && (is_up || is_down);
            ent_ctl_reg.up     <= is_up;
            ent_ctl_reg.last   <= s_last;
            ent_ctl_reg.ovf    <= ovf_reg || full;
            if (accept) begin
                if (s_last) begin
                    item_count_reg <= '0;
                    ovf_reg        <= 1'b0;
                end else begin
                    item_count_reg <= full ? item_count_reg : item_count_reg + CNT_W'(1);
                    ovf_reg        <= ovf_reg || full;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ent_idx_reg  <= item_count_reg[IDX_W-1:0];
            ent_pred_reg <= s_predicted;
        end
    end

    assign ctl_chain[0]   = ent_ctl_reg;
    assign idx_chain[0]   = ent_idx_reg;
    assign pred_chain[0]  = ent_pred_reg;
    assign score_chain[0] = '0;
    assign pairs_chain[0] = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        nsrank_cell #(
            .MAX_ITEMS (MAX_ITEMS),
            .INDEX     (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .tie_credit (tie_reg),
            .ctl_in     (ctl_chain[k]),
            .idx_in     (idx_chain[k]),
            .pred_in    (pred_chain[k]),
            .score_in   (score_chain[k]),
            .pairs_in   (pairs_chain[k]),
            .ctl_out    (ctl_chain[k+1]),
            .idx_out    (idx_chain[k+1]),
            .pred_out   (pred_chain[k+1]),
            .score_out  (score_chain[k+1]),
            .pairs_out  (pairs_chain[k+1])
        );
    end

    // tail accumulator
    assign total_sum   = sum_reg + SUM_W'(score_chain[MAX_ITEMS]);
    assign total_pairs = pairs_reg + PAIR_W'(pairs_chain[MAX_ITEMS]);
    assign div_start   = tail_ctl.valid && tail_ctl.last && div_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            pairs_reg <= '0;
        end else if (adv && tail_ctl.valid) begin
            if (tail_ctl.last) begin
                sum_reg   <= '0;
                pairs_reg <= '0;
            end else begin
                sum_reg   <= total_sum;
                pairs_reg <= total_pairs;
            end
        end
    end

    nsrank_div #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .sum_in       (total_sum),
        .pairs_in     (total_pairs),
        .ovf_in       (tail_ctl.ovf),
        .idle         (div_idle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accuracy   (m_accuracy),
        .m_pair_total (m_pair_total),
        .m_undefined  (m_undefined),
        .m_overflowed (m_overflowed)
    );

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        item_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last |=> item_count_reg == '0 && !ovf_reg)
        else $error("set not cleared after last beat");

    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(tail_ctl) && $stable(total_sum))
        else $error("cell row moved during stall");

    a_pairs_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && tail_ctl.valid && !tail_ctl.last |=> pairs_reg >= $past(pairs_reg))
        else $error("pair count wrapped");
`endif

endmodule

// ===== hdl/nsrank_cell.sv =====
// One chain cell: holds one item and scores later active beats against it.
`timescale 1ns / 1ps

module nsrank_cell #(
    parameter int MAX_ITEMS = nsrank_pkg::MAX_ITEMS_DEF,
    parameter int INDEX     = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic [nsrank_pkg::TIE_W-1:0]        tie_credit,
    input  nsrank_pkg::tok_ctl_t                ctl_in,
    input  logic [$clog2(MAX_ITEMS)-1:0]        idx_in,
    input  logic [nsrank_pkg::DATA_W-1:0]       pred_in,
    input  logic [$clog2(MAX_ITEMS)+7:0]        score_in,
    input  logic [$clog2(MAX_ITEMS)-1:0]        pairs_in,
    output nsrank_pkg::tok_ctl_t                ctl_out,
    output logic [$clog2(MAX_ITEMS)-1:0]        idx_out,
    output logic [nsrank_pkg::DATA_W-1:0]       pred_out,
    output logic [$clog2(MAX_ITEMS)+7:0]        score_out,
    output logic [$clog2(MAX_ITEMS)-1:0]        pairs_out
);

    localparam int IDX_W    = $clog2(MAX_ITEMS);
    localparam int TSCORE_W = IDX_W + 8;

    logic                            nz_reg;
    logic                            up_reg;
    logic [nsrank_pkg::DATA_W-1:0]   pred_reg;

    nsrank_pkg::tok_ctl_t            ctl_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [nsrank_pkg::DATA_W-1:0]   pred_out_reg;
    logic [TSCORE_W-1:0]             score_reg;
    logic [IDX_W-1:0]                pairs_reg;

    logic                            hit;
    logic                            wr;
    logic                            gt;
    logic                            lt;
    logic                            eq;
    logic                            win;
    logic [nsrank_pkg::TIE_W-1:0]    credit;

    assign hit = ctl_in.valid && ctl_in.active && nz_reg && (IDX_W'(INDEX) < idx_in);
    assign wr  = adv && ctl_in.valid && ctl_in.store && (idx_in == IDX_W'(INDEX));
    assign gt  = $signed(pred_reg) > $signed(pred_in);
    assign lt  = $signed(pred_reg) < $signed(pred_in);
    assign eq  = pred_reg == pred_in;

    always_comb begin
        win = up_reg ? (gt || (eq && (tie_credit != '0))) : lt;
        if (up_reg == ctl_in.up) begin
            credit = tie_credit;
        end else if (win) begin
            credit = nsrank_pkg::SCORE_ONE;
        end else begin
            credit = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            nz_reg   <= ctl_in.active;
            up_reg   <= ctl_in.up;
            pred_reg <= pred_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg      <= idx_in;
            pred_out_reg <= pred_in;
            score_reg    <= hit ? score_in + TSCORE_W'(credit) : score_in;
            pairs_reg    <= hit ? pairs_in + IDX_W'(1) : pairs_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign idx_out   = idx_reg;
    assign pred_out  = pred_out_reg;
    assign score_out = score_reg;
    assign pairs_out = pairs_reg;

endmodule

// ===== hdl/nsrank_div.sv =====
// Rounded mean-score divider and result output register.
`timescale 1ns / 1ps

module nsrank_div #(
    parameter int MAX_ITEMS = nsrank_pkg::MAX_ITEMS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [2*$clog2(MAX_ITEMS)+7:0]         sum_in,
    input  logic [2*$clog2(MAX_ITEMS)-1:0]         pairs_in,
    input  logic                                   ovf_in,
    output logic                                   idle,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [nsrank_pkg::ACC_W-1:0]           m_accuracy,
    output logic [nsrank_pkg::PTOT_W-1:0]          m_pair_total,
    output logic                                   m_undefined,
    output logic                                   m_overflowed
);

    localparam int IDX_W   = $clog2(MAX_ITEMS);
    localparam int PAIR_W  = 2 * IDX_W;
    localparam int SUM_W   = PAIR_W + 8;
    localparam int NUM_W   = SUM_W + 10;
    localparam int ACC_W   = nsrank_pkg::ACC_W;
    localparam int REM_W   = NUM_W - ACC_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int EXT_W   = (PAIR_W > nsrank_pkg::PTOT_W) ? PAIR_W : nsrank_pkg::PTOT_W;

    nsrank_pkg::div_state_t state_reg, state_next;

    logic [REM_W-1:0]                 rem_reg;
    logic [REM_W-1:0]                 den_reg;
    logic [ACC_W-1:0]                 q_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [nsrank_pkg::PTOT_W-1:0]    ptot_reg;
    logic                             undef_reg;
    logic                             ovf_reg;

    logic [NUM_W-1:0]                 num;
    logic [EXT_W-1:0]                 pairs_ext;
    logic [REM_W:0]                   rem_sh;
    logic [REM_W:0]                   rem_sub;
    logic                             ge;

    assign num       = {sum_in, 9'b0} + NUM_W'(pairs_in);
    assign pairs_ext = EXT_W'(pairs_in);
    assign rem_sh    = {rem_reg, q_reg[ACC_W-1]};
    assign rem_sub   = rem_sh - {1'b0, den_reg};
    assign ge        = rem_sh >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nsrank_pkg::DIV_IDLE: begin
                if (start) begin
                    state_next = (pairs_in == '0) ? nsrank_pkg::DIV_OUT : nsrank_pkg::DIV_RUN;
                end
            end
            nsrank_pkg::DIV_RUN: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = nsrank_pkg::DIV_OUT;
                end
            end
            nsrank_pkg::DIV_OUT: begin
                if (m_ready) begin
                    state_next = nsrank_pkg::DIV_IDLE;
                end
            end
            default: state_next = nsrank_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nsrank_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == nsrank_pkg::DIV_IDLE && start) begin
            rem_reg   <= num[NUM_W-1:ACC_W];
            den_reg   <= {pairs_in, 1'b0};
            q_reg     <= (pairs_in == '0) ? '0 : num[ACC_W-1:0];
            cnt_reg   <= CNT_W'(ACC_W);
            undef_reg <= pairs_in == '0;
            ovf_reg   <= ovf_in;
            ptot_reg  <= (pairs_ext > EXT_W'(nsrank_pkg::PAIR_FIELD_MAX)) ?
                         nsrank_pkg::PAIR_FIELD_MAX : pairs_ext[nsrank_pkg::PTOT_W-1:0];
        end else if (state_reg == nsrank_pkg::DIV_RUN) begin
            rem_reg <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            q_reg   <= {q_reg[ACC_W-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign idle         = state_reg == nsrank_pkg::DIV_IDLE;
    assign m_valid      = state_reg == nsrank_pkg::DIV_OUT;
    assign m_accuracy   = q_reg;
    assign m_pair_total = ptot_reg;
    assign m_undefined  = undef_reg;
    assign m_overflowed = ovf_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == nsrank_pkg::DIV_RUN |-> rem_reg < den_reg)
        else $error("divider remainder out of range");

    a_acc_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_accuracy <= nsrank_pkg::ACC_ONE)
        else $error("accuracy above one");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_undefined |-> m_accuracy == '0 && m_pair_total == '0)
        else $error("undefined result carries data");
`endif

endmodule

// ===== tb/sv/tb_null_stratified_rank_accuracy.sv =====
// Self-checking testbench for the null-stratified rank accuracy scorer.
`timescale 1ns / 1ps

module tb_null_stratified_rank_accuracy;

    localparam int MAX_ITEMS   = nsrank_pkg::MAX_ITEMS_DEF;
    localparam int DATA_W      = nsrank_pkg::DATA_W;
    localparam int ACC_W       = nsrank_pkg::ACC_W;
    localparam int PTOT_W      = nsrank_pkg::PTOT_W;
    localparam int EPS_W       = nsrank_pkg::EPS_W;
    localparam int TIE_W       = nsrank_pkg::TIE_W;
    localparam int CFG_W       = nsrank_pkg::CFG_W;
    localparam int SETTLE      = MAX_ITEMS + 40;
    localparam int LONG_HOLD   = 3 * MAX_ITEMS;
    localparam int STALL_LIMIT = 16 * MAX_ITEMS + 4000;
    localparam int OVF_LEN     = MAX_ITEMS + 6;
    localparam int N_DIR       = 14;
    localparam int N_PH        = 11;
    localparam int HOLD_PH     = 2;

    typedef struct packed {
        logic [ACC_W-1:0]  accuracy;
        logic [PTOT_W-1:0] pair_total;
        logic              undefined;
        logic              overflowed;
    } score_res_t;

    typedef struct {
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] pred;
        logic                     lst;
        bit                       has_want;
        score_res_t               want;
    } beat_row_t;

    localparam score_res_t NO_RES = '0;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [0:0]               cfg_idx;
    logic [CFG_W-1:0]         cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_measured;
    logic signed [DATA_W-1:0] s_predicted;
    logic                     s_last;
    logic                     m_valid;
    logic                     m_ready;
    logic [ACC_W-1:0]         m_accuracy;
    logic [PTOT_W-1:0]        m_pair_total;
    logic                     m_undefined;
    logic                     m_overflowed;

    // scorer mirror
    logic [EPS_W-1:0]         eps_cfg;
    logic [TIE_W-1:0]         tie_cfg;
    int                       dir_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] pred_mem [MAX_ITEMS];
    int                       held_cnt;
    longint                   score_acc;
    longint                   pair_acc;
    bit                       dropped;

    score_res_t               pending_acc [$];
    int                       errors = 0;
    int                       tx_pct = 0;
    int                       rx_pct = 0;
    bit                       hold_req = 1'b0;
    logic signed [DATA_W-1:0] prev_pred = '0;
    beat_row_t                dir_tab [N_DIR];

    null_stratified_rank_accuracy #(.MAX_ITEMS(MAX_ITEMS)) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_measured  (s_measured),
        .s_predicted (s_predicted),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accuracy  (m_accuracy),
        .m_pair_total(m_pair_total),
        .m_undefined (m_undefined),
        .m_overflowed(m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_scores();
        held_cnt  = 0;
        score_acc = 0;
        pair_acc  = 0;
        dropped   = 1'b0;
    endfunction

    // Scores one accepted beat; returns 1 with the result when the beat closes a set.
    function automatic bit rank_score_beat(input logic signed [DATA_W-1:0] m,
                                           input logic signed [DATA_W-1:0] p,
                                           input logic lst, output score_res_t r);
        int     s;
        int     e;
        int     k;
        int     dm;
        int     dp;
        int     prod;
        longint q;
        r = '0;
        e = int'(eps_cfg);
        if (held_cnt >= MAX_ITEMS) begin
            dropped = 1'b1;
        end else begin
            if (int'(m) > e) s = 1;
            else if (int'(m) < -e) s = -1;
            else s = 0;
            if (s != 0) begin
                for (k = 0; k < held_cnt; k++) begin
                    if (dir_mem[k] != 0) begin
                        dm = dir_mem[k] - s;
                        if (pred_mem[k] > p) dp = 256;
                        else if (pred_mem[k] < p) dp = -256;
                        else dp = int'(tie_cfg);
                        prod = dm * dp;
                        if (prod > 0) score_acc += 256;
                        else if (prod == 0) score_acc += longint'(tie_cfg);
                        pair_acc++;
                    end
                end
            end
            dir_mem[held_cnt]  = s;
            pred_mem[held_cnt] = p;
            held_cnt++;
        end
        if (!lst) return 1'b0;
        if (pair_acc == 0) begin
            r.undefined = 1'b1;
        end else begin
            q = (score_acc * 512 + pair_acc) / (2 * pair_acc);
            r.accuracy = q[ACC_W-1:0];
        end
        r.pair_total = (pair_acc > nsrank_pkg::PAIR_FIELD_MAX) ?
                       nsrank_pkg::PAIR_FIELD_MAX : pair_acc[PTOT_W-1:0];
        r.overflowed = dropped;
        clear_scores();
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_measured();
        int e;
        int v;
        e = int'(eps_cfg);
        case ($urandom_range(0, 9))
            0, 1: v = int'($urandom_range(0, 65535)) - 32768;
            2: v = e;
            3: v = e + 1;
            4: v = -e;
            5: v = -e - 1;
            6: v = 0;
            7: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 2 * e + 8)) - e - 4;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_predicted();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = int'($urandom_range(0, 65535)) - 32768;
            2: v = int'($urandom_range(0, 4)) - 2;
            3: v = int'(prev_pred);
            4: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 64)) - 32;
        endcase
        return v[DATA_W-1:0];
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    task automatic write_cfg(input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] t);
        cfg_we   <= 1'b1;
        cfg_idx  <= nsrank_pkg::REG_EPSILON;
        cfg_data <= e;
        @(posedge aclk);
        eps_cfg  = e[EPS_W-1:0];
        cfg_idx  <= nsrank_pkg::REG_TIE_CREDIT;
        cfg_data <= t;
        @(posedge aclk);
        tie_cfg  = (t[TIE_W-1:0] > nsrank_pkg::SCORE_ONE) ?
                   nsrank_pkg::SCORE_ONE : t[TIE_W-1:0];
        cfg_we   <= 1'b0;
    endtask

    task automatic send_beat(input logic signed [DATA_W-1:0] m,
                             input logic signed [DATA_W-1:0] p,
                             input logic lst, input bit has_want, input score_res_t want);
        score_res_t r;
        int         n;
        if ($urandom_range(0, 99) < tx_pct) begin
            n = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_measured  <= m;
        s_predicted <= p;
        s_last      <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (rank_score_beat(m, p, lst, r)) pending_acc.push_back(has_want ? want : r);
    endtask

    task automatic run_set(input int len);
        int                       i;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] p;
        for (i = 0; i < len; i++) begin
            m = pick_measured();
            p = pick_predicted();
            prev_pred = p;
            send_beat(m, p, i == len - 1, 1'b0, NO_RES);
        end
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_acc.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result side: random back-pressure plus one long hold
    initial begin : rx_side
        int n;
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if ($urandom_range(0, 99) < rx_pct) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        score_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_acc.size() == 0) begin
                $display("%0t: result beat with none expected, accuracy %0d pairs %0d",
                         $time, m_accuracy, m_pair_total);
                errors++;
            end else begin
                want = pending_acc.pop_front();
                check_field("accuracy", 32'(want.accuracy), 32'(m_accuracy));
                check_field("pair_total", 32'(want.pair_total), 32'(m_pair_total));
                check_field("undefined", 32'(want.undefined), 32'(m_undefined));
                check_field("overflowed", 32'(want.overflowed), 32'(m_overflowed));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stim
        int               i;
        int               ph;
        int               budget;
        int               sent;
        int               len;
        logic [CFG_W-1:0] e;
        logic [CFG_W-1:0] t;

        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_idx     <= nsrank_pkg::REG_EPSILON;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_measured  <= '0;
        s_predicted <= '0;
        s_last      <= 1'b0;
        eps_cfg     = nsrank_pkg::EPS_RESET;
        tie_cfg     = nsrank_pkg::TIE_RESET;
        clear_scores();

        dir_tab = '{
            '{16'sd0,   16'sd0,   1'b1, 1'b1, '{17'd0, 19'd0, 1'b1, 1'b0}},
            '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, NO_RES},
            '{16'h8000, 16'h8000, 1'b1, 1'b1, '{nsrank_pkg::ACC_ONE, 19'd1, 1'b0, 1'b0}},
            '{16'sd1,   16'sd5,   1'b0, 1'b0, NO_RES},
            '{16'sd2,   16'sd5,   1'b1, 1'b1, '{17'd32768, 19'd1, 1'b0, 1'b0}},
            '{-16'sd1,  16'sd3,   1'b0, 1'b0, NO_RES},
            '{16'sd1,   16'sd3,   1'b1, 1'b1, '{17'd0, 19'd1, 1'b0, 1'b0}},
            '{16'h8000, 16'h7FFF, 1'b1, 1'b1, '{17'd0, 19'd0, 1'b1, 1'b0}},
            '{16'sd0,   16'h8000, 1'b0, 1'b0, NO_RES},
            '{16'h5555, 16'hAAAA, 1'b0, 1'b0, NO_RES},
            '{16'hAAAA, 16'h5555, 1'b0, 1'b0, NO_RES},
            '{16'h8000, 16'sd0,   1'b0, 1'b0, NO_RES},
            '{16'h7FFF, -16'sd1,  1'b0, 1'b0, NO_RES},
            '{16'sd5,   -16'sd1,  1'b1, 1'b0, NO_RES}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: dead band 0, half credit for ties
        tx_pct = 15;
        rx_pct = 15;
        for (i = 0; i < N_DIR; i++) begin
            send_beat(dir_tab[i].meas, dir_tab[i].pred, dir_tab[i].lst,
                      dir_tab[i].has_want, dir_tab[i].want);
        end
        drain_and_settle();

        // one set past capacity
        write_cfg('0, 15'd256);
        run_set(OVF_LEN);
        drain_and_settle();

        for (ph = 0; ph < N_PH; ph++) begin
            case (ph)
                0: begin
                    e = 15'h7FFF;
                    t = 15'd0;
                end
                1: begin
                    e = '0;
                    t = 15'h01FF;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: e = '0;
                        1: e = 15'd1;
                        2: e = 15'($urandom_range(2, 300));
                        3: e = 15'($urandom_range(0, 32767));
                        default: e = 15'h7FFF;
                    endcase
                    if ($urandom_range(0, 1) != 0) t = 15'($urandom_range(0, 256));
                    else t = 15'($urandom_range(0, 32767));
                end
            endcase
            write_cfg(e, t);
            if (ph >= N_PH - 2) begin
                tx_pct = 0;
                rx_pct = 0;
            end else if (ph == HOLD_PH) begin
                tx_pct = 100;
                rx_pct = 0;
                hold_req = 1'b1;
            end else begin
                tx_pct = 20 * $urandom_range(0, 2);
                rx_pct = 20 * $urandom_range(0, 2);
            end
            budget = (ph == HOLD_PH) ? 200 : 55;
            sent = 0;
            while (sent < budget) begin
                // short sets during the hold, so a second last beat reaches the tail early
                if (ph != HOLD_PH && $urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
                else len = $urandom_range(1, 12);
                run_set(len);
                sent += len;
            end
            drain_and_settle();
        end

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== null_stratified_rank_accuracy.f =====
hdl/nsrank_pkg.sv
hdl/nsrank_cell.sv
hdl/nsrank_div.sv
hdl/null_stratified_rank_accuracy.sv
tb/sv/tb_null_stratified_rank_accuracy.sv
